>>> sv/assert_macros.svh
// Assertion macros shared by the moving average RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESMA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ESMA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/esma_pkg.sv
// Shared types and constants for the edge-shrinking moving average.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package esma_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_SPAN_DEF = 31;
  localparam int SPAN_BITS    = 5;
  localparam int SPAN_RESET   = 5;
  localparam int CNT_BITS     = 5;
  localparam int HALF_BITS    = CNT_BITS - 1;
  localparam int SUM_BITS     = SAMPLE_BITS + CNT_BITS;
  localparam int SEEN_BITS    = 6;
  localparam int SEEN_MAX     = 63;
  localparam int LAG_BITS     = 5;
  localparam int LAG_MAX      = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          final_out;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
    logic [CNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> sv/esma_hist.sv
// Circular sample history: one write port, one registered read port.
// Depends on esma_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none
module esma_hist #(
  parameter  int DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire                             clk,
  input  wire                             we,
  input  wire  [AW-1:0]                   waddr,
  input  wire  [esma_pkg::SAMPLE_BITS-1:0] wdata,
  input  wire  [AW-1:0]                   raddr,
  output logic [esma_pkg::SAMPLE_BITS-1:0] rdata
);
  import esma_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/esma_div.sv
// Restoring divider, one quotient bit per cycle, for an odd divisor.
// Depends on esma_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none
module esma_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire esma_pkg::div_req_t  req,
  output esma_pkg::div_rsp_t       rsp
);
  import esma_pkg::*;

  localparam int STEP_BITS = $clog2(SAMPLE_BITS + 1);

  logic                   busy_r,  busy_nxt;
  logic                   done_r,  done_nxt;
  logic [STEP_BITS-1:0]   step_r,  step_nxt;
  logic [CNT_BITS-1:0]    rem_r,   rem_nxt;
  logic [SAMPLE_BITS-1:0] dvd_r,   dvd_nxt;
  logic [CNT_BITS-1:0]    dsr_r,   dsr_nxt;
  logic [CNT_BITS:0]      sh_c;
  logic [CNT_BITS:0]      diff_c;
  logic                   ge_c;

  always_comb begin
    sh_c   = {rem_r, dvd_r[SAMPLE_BITS-1]};
    diff_c = sh_c - {1'b0, dsr_r};
    ge_c   = sh_c >= {1'b0, dsr_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_BITS'(SAMPLE_BITS);
      // upper bits are already below the divisor, quotient fits SAMPLE_BITS
      rem_nxt  = req.dividend[SUM_BITS-1 -: CNT_BITS];
      dvd_nxt  = req.dividend[SAMPLE_BITS-1:0];
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = ge_c ? diff_c[CNT_BITS-1:0] : sh_c[CNT_BITS-1:0];
      dvd_nxt  = {dvd_r[SAMPLE_BITS-2:0], ge_c};
      step_nxt = step_r - STEP_BITS'(1);
      if (step_r == STEP_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;

endmodule
`default_nettype wire

>>> sv/edge_shrinking_moving_average_core.sv
// Centered moving average with windows that shrink at block ends.
// Per output: check, one history read per window tap, one divider step per quotient bit,
// then load into the output register; each item is first accepted and then checked. No
// new item is taken until all of its outputs are in the output register. Reset (rst_n
// low, synchronous): counters cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module edge_shrinking_moving_average_core #(
  parameter int MAX_SPAN = esma_pkg::MAX_SPAN_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire esma_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output esma_pkg::out_item_t             out_data,
  input  wire                             cfg_we,
  input  wire  [esma_pkg::SPAN_BITS-1:0]  cfg_wdata
);
  import esma_pkg::*;

  localparam int HIST_LEN = MAX_SPAN + 1;
  localparam int PTR_BITS = $clog2(HIST_LEN);
  localparam int MAX_HALF = (MAX_SPAN - 1) / 2;

  state_t                state_r, state_nxt;
  logic [SPAN_BITS-1:0]  span_r,  span_nxt;
  logic [PTR_BITS-1:0]   wp_r,    wp_nxt;
  logic [SEEN_BITS-1:0]  seen_r,  seen_nxt;
  logic [LAG_BITS-1:0]   lag_r,   lag_nxt;
  logic                  last_r,  last_nxt;
  logic [HALF_BITS-1:0]  pn_r,    pn_nxt;
  logic [CNT_BITS-1:0]   iss_r,   iss_nxt;
  logic [LAG_BITS-1:0]   t_r,     t_nxt;
  logic                  pend_r,  pend_nxt;
  logic signed [SUM_BITS-1:0] acc_r, acc_nxt;
  logic                  fin_r,   fin_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r,   out_nxt;

  logic                  in_xfer;
  logic                  out_load;
  logic [HALF_BITS-1:0]  half_c, n_c, pn_c;
  logic [LAG_BITS-1:0]   d_c;
  logic [SEEN_BITS-1:0]  i_c;
  logic                  emit_c;
  logic                  sum_done_c;
  logic [PTR_BITS:0]     raw_c;
  logic [PTR_BITS-1:0]   raddr_c;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SUM_BITS-1:0]   mag_c;
  logic [SAMPLE_BITS-1:0] qneg_c;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  esma_hist #(.DEPTH(HIST_LEN)) u_hist (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wp_r),
    .wdata (in_data.sample),
    .raddr (raddr_c),
    .rdata (rdata)
  );

  esma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // half-width, window center and shrunken half-width
  always_comb begin
    half_c = (span_r == '0) ? '0 : HALF_BITS'((span_r - SPAN_BITS'(1)) >> 1);
    n_c    = (32'(half_c) > 32'(MAX_HALF)) ? HALF_BITS'(MAX_HALF) : half_c;
    d_c    = lag_r - LAG_BITS'(1);
    i_c    = seen_r - SEEN_BITS'(1) - SEEN_BITS'(d_c);
    pn_c   = n_c;
    if (i_c < SEEN_BITS'(pn_c)) begin
      pn_c = HALF_BITS'(i_c);
    end
    if (d_c < LAG_BITS'(pn_c)) begin
      pn_c = HALF_BITS'(d_c);
    end
    emit_c = (lag_r > LAG_BITS'(n_c)) || (last_r && (lag_r != '0));
  end

  // ring address of the tap t_r behind the newest sample
  always_comb begin
    raw_c = {1'b0, wp_r} + (PTR_BITS+1)'(HIST_LEN - 1) - (PTR_BITS+1)'(t_r);
    if (raw_c >= (PTR_BITS+1)'(HIST_LEN)) begin
      raw_c = raw_c - (PTR_BITS+1)'(HIST_LEN);
    end
    raddr_c = raw_c[PTR_BITS-1:0];
  end

  always_comb begin
    sum_done_c = (iss_r == '0) && !pend_r;
    mag_c      = acc_r[SUM_BITS-1] ? SUM_BITS'(~acc_r + SUM_BITS'(1)) : SUM_BITS'(acc_r);
    qneg_c     = ~div_rsp.quot + SAMPLE_BITS'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = emit_c ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (sum_done_c) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall         = !rst_n || (state_r != ST_IDLE);
    in_xfer          = in_valid && !in_stall;
    out_load         = 1'b0;
    span_nxt         = cfg_we ? cfg_wdata : span_r;
    wp_nxt           = wp_r;
    seen_nxt         = seen_r;
    lag_nxt          = lag_r;
    last_nxt         = last_r;
    pn_nxt           = pn_r;
    iss_nxt          = iss_r;
    t_nxt            = t_r;
    pend_nxt         = 1'b0;
    acc_nxt          = acc_r;
    fin_nxt          = fin_r;
    out_nxt          = out_r;
    div_req.start    = 1'b0;
    div_req.dividend = mag_c + SUM_BITS'(pn_r);
    div_req.divisor  = {pn_r, 1'b1};
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          wp_nxt   = (wp_r == PTR_BITS'(HIST_LEN - 1)) ? '0 : wp_r + PTR_BITS'(1);
          seen_nxt = (seen_r == SEEN_BITS'(SEEN_MAX)) ? seen_r : seen_r + SEEN_BITS'(1);
          lag_nxt  = (lag_r == LAG_BITS'(LAG_MAX)) ? lag_r : lag_r + LAG_BITS'(1);
          last_nxt = in_data.block_end;
        end
      end
      ST_CHECK: begin
        if (emit_c) begin
          pn_nxt  = pn_c;
          iss_nxt = {pn_c, 1'b1};
          t_nxt   = d_c - LAG_BITS'(pn_c);
          acc_nxt = '0;
          fin_nxt = last_r && (d_c == '0);
        end else if (last_r) begin
          seen_nxt = '0;
          lag_nxt  = '0;
        end
      end
      ST_SUM: begin
        if (iss_r != '0) begin
          iss_nxt  = iss_r - CNT_BITS'(1);
          t_nxt    = t_r + LAG_BITS'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          acc_nxt = acc_r + {{CNT_BITS{rdata[SAMPLE_BITS-1]}}, rdata};
        end
        div_req.start = sum_done_c;
      end
      ST_DIV: begin
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load          = 1'b1;
          out_nxt.smoothed  = acc_r[SUM_BITS-1] ? qneg_c : div_rsp.quot;
          out_nxt.final_out = fin_r;
          lag_nxt           = lag_r - LAG_BITS'(1);
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      span_r      <= SPAN_BITS'(SPAN_RESET);
      wp_r        <= '0;
      seen_r      <= '0;
      lag_r       <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      span_r      <= span_nxt;
      wp_r        <= wp_nxt;
      seen_r      <= seen_nxt;
      lag_r       <= lag_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r <= last_nxt;
    pn_r   <= pn_nxt;
    t_r    <= t_nxt;
    acc_r  <= acc_nxt;
    fin_r  <= fin_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ESMA_ASSERT_NXT(a_check_after_xfer, clk, rst_n, in_xfer, state_r == ST_CHECK)
  `ESMA_ASSERT_NXT(a_final_clears_lag, clk, rst_n, out_load && out_nxt.final_out, lag_r == '0)
  `ESMA_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_rsp.done, state_r == ST_DIV)
  `ESMA_ASSERT_IMP(a_load_only_free, clk, rst_n, out_load, !out_valid_r || !out_stall)

endmodule
`default_nettype wire
